// File: hdl/pit_pkg.sv
// Shared types and helpers for the point-in-triangle test pipeline.
package pit_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned PackW  = 3 * CoordW;
	localparam int unsigned NumVert = 3;

	typedef logic [PackW-1:0] packed_xyz_t;
	typedef logic signed [CoordW-1:0] coord_t;

	// Coordinate selector within a packed triple
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Per-edge outcome handed from an edge unit to the combining logic
	typedef struct packed {
		logic straddle;  // ends lie on opposite sides of the horizontal through the point
		logic toggle;    // flip the crossing parity
		logic on_edge;   // point lies on this straddling edge
		logic touch;     // non-straddling edge touches the point at the horizontal line
	} edge_stat_t;

	// Pull one signed coordinate out of a packed triple
	function automatic coord_t coord_of(input packed_xyz_t p, input axis_t ax);
		coord_t c;
		case (ax)
			AXIS_X:  c = p[CoordW-1:0];
			AXIS_Y:  c = p[2*CoordW-1:CoordW];
			AXIS_Z:  c = p[3*CoordW-1:2*CoordW];
			default: c = p[CoordW-1:0];
		endcase
		return c;
	endfunction

	// Magnitude of a signed coordinate, one bit wider so that the most negative value fits
	function automatic logic [CoordW:0] mag_of(input coord_t c);
		logic signed [CoordW:0] w;
		w = {c[CoordW-1], c};
		return w[CoordW] ? $unsigned(-w) : $unsigned(w);
	endfunction

endpackage

// File: hdl/pit_edge.sv
// One edge of the crossing-number test: product stage and edge classification.
module pit_edge (
	input  logic             clk,
	input  pit_pkg::coord_t  x0,
	input  pit_pkg::coord_t  y0,
	input  pit_pkg::coord_t  x1,
	input  pit_pkg::coord_t  y1,
	input  pit_pkg::coord_t  tx,
	input  pit_pkg::coord_t  ty,
	output pit_pkg::edge_stat_t stat
);
	import pit_pkg::*;

	logic                signed [CoordW:0]     dxp, dy, dx, dyp;
	logic                       [CoordW:0]     dy_abs;
	logic                signed [2*CoordW+1:0] prod_a, prod_b;
	logic                                      f0, f1, s0, s1;
	logic                                      touch_c;

	logic                signed [2*CoordW+1:0] prod_a_s3, prod_b_s3;
	logic                                      dy_neg_s3;
	logic                       [CoordW-2:0]   half_s3;
	logic                                      straddle_s3, same_s3, s0_s3, touch_s3;

	logic                signed [2*CoordW+2:0] ix, ix_adj, half_ext;
	logic                                      above;

	// Form differences and sides of the point
	always_comb begin
		dxp    = {x1[CoordW-1], x1} - {tx[CoordW-1], tx};
		dy     = {y0[CoordW-1], y0} - {y1[CoordW-1], y1};
		dx     = {x0[CoordW-1], x0} - {x1[CoordW-1], x1};
		dyp    = {y1[CoordW-1], y1} - {ty[CoordW-1], ty};
		dy_abs = dy[CoordW] ? $unsigned(-dy) : $unsigned(dy);
		prod_a = dxp * dy;
		prod_b = dyp * dx;
		f0     = (y0 >= ty);
		f1     = (y1 >= ty);
		s0     = (x0 >= tx);
		s1     = (x1 >= tx);
	end

	// Detect a touch of the point's horizontal line by a non-straddling edge
	always_comb begin
		touch_c = 1'b0;
		if (f1 && (ty == y0)) begin
			if (ty == y1) begin
				if (((x0 < tx) == (x1 < tx)) && (tx != x0))
					touch_c = (tx == x1);
				else
					touch_c = 1'b1;
			end else begin
				touch_c = (tx == x0);
			end
		end
	end

	// Hold products and flags for the combining stage
	always_ff @(posedge clk) begin
		prod_a_s3   <= prod_a;
		prod_b_s3   <= prod_b;
		dy_neg_s3   <= dy[CoordW];
		half_s3     <= dy_abs[CoordW-1:1];
		straddle_s3 <= (f0 != f1);
		same_s3     <= (s0 == s1);
		s0_s3       <= s0;
		touch_s3    <= touch_c;
	end

	// Compare the cross value against half the vertical extent
	always_comb begin
		ix       = {prod_a_s3[2*CoordW+1], prod_a_s3} - {prod_b_s3[2*CoordW+1], prod_b_s3};
		ix_adj   = dy_neg_s3 ? -ix : ix;
		half_ext = $signed({{(CoordW+4){1'b0}}, half_s3});
		above    = (ix_adj > half_ext);

		stat.straddle = straddle_s3;
		stat.toggle   = straddle_s3 & (same_s3 ? s0_s3 : above);
		stat.on_edge  = straddle_s3 & ~same_s3 & ~above & (ix_adj >= -half_ext);
		stat.touch    = ~straddle_s3 & touch_s3;
	end

endmodule

// File: hdl/point_in_triangle_test.sv
// Top level of the point-in-triangle test: projection, edge units and result stage.
// The result strobe done is registered from start through valid_s1, valid_s2 and valid_s3.
// Throughput: one query per cycle; busy is held low, the four-stage pipeline never stalls.
// The receiver cannot stall: each result shows on inside_res for the single cycle of done.
// Reset clears the stage valid flags and the strobe; data registers are not reset.
module point_in_triangle_test (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pit_pkg::packed_xyz_t vertex_a,
	input  pit_pkg::packed_xyz_t vertex_b,
	input  pit_pkg::packed_xyz_t vertex_c,
	input  pit_pkg::packed_xyz_t query_point,
	input  pit_pkg::packed_xyz_t face_normal,
	output logic                 done,
	output logic                 inside_res
);
	import pit_pkg::*;

	packed_xyz_t vert_s1 [NumVert];
	packed_xyz_t point_s1, normal_s1;
	logic        valid_s1, valid_s2, valid_s3;

	logic [CoordW:0] nx, ny, nz;
	axis_t           ax, ay;

	coord_t px_s2 [NumVert];
	coord_t py_s2 [NumVert];
	coord_t tx_s2, ty_s2;

	edge_stat_t stat [NumVert];

	logic inside_c;
	logic done_q, inside_q;

	assign busy = 1'b0;

	// Capture the query on each start transfer
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			vert_s1[0] <= vertex_a;
			vert_s1[1] <= vertex_b;
			vert_s1[2] <= vertex_c;
			point_s1   <= query_point;
			normal_s1  <= face_normal;
		end
	end

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	// Pick the projection plane from the dominant normal axis; a tie with Z picks XY, an X-Y tie picks XZ
	always_comb begin
		nx = mag_of(coord_of(normal_s1, AXIS_X));
		ny = mag_of(coord_of(normal_s1, AXIS_Y));
		nz = mag_of(coord_of(normal_s1, AXIS_Z));
		if (ny < nx) begin
			if (nz < nx) begin
				ax = AXIS_Y;
				ay = AXIS_Z;
			end else begin
				ax = AXIS_X;
				ay = AXIS_Y;
			end
		end else begin
			if (nz < ny) begin
				ax = AXIS_X;
				ay = AXIS_Z;
			end else begin
				ax = AXIS_X;
				ay = AXIS_Y;
			end
		end
	end

	// Hold the projected coordinates
	always_ff @(posedge clk) begin
		for (int k = 0; k < NumVert; k++) begin
			px_s2[k] <= coord_of(vert_s1[k], ax);
			py_s2[k] <= coord_of(vert_s1[k], ay);
		end
		tx_s2 <= coord_of(point_s1, ax);
		ty_s2 <= coord_of(point_s1, ay);
	end

	// Evaluate edges c-a, a-b and b-c in parallel
	for (genvar e = 0; e < NumVert; e++) begin : g_edge
		localparam int Prev = (e + NumVert - 1) % NumVert;
		pit_edge u_edge (
			.clk  (clk),
			.x0   (px_s2[Prev]),
			.y0   (py_s2[Prev]),
			.x1   (px_s2[e]),
			.y1   (py_s2[e]),
			.tx   (tx_s2),
			.ty   (ty_s2),
			.stat (stat[e])
		);
	end

	// Walk the edges in order: parity, boundary hits and the stop after two crossings
	always_comb begin
		logic parity, crossed, fin;
		parity   = 1'b0;
		crossed  = 1'b0;
		fin      = 1'b0;
		inside_c = 1'b0;
		for (int e = 0; e < NumVert; e++) begin
			if (!fin) begin
				if (stat[e].straddle) begin
					if (stat[e].on_edge) begin
						inside_c = 1'b1;
						fin      = 1'b1;
					end else begin
						parity = parity ^ stat[e].toggle;
						if (crossed) begin
							inside_c = parity;
							fin      = 1'b1;
						end
						crossed = 1'b1;
					end
				end else if (stat[e].touch) begin
					inside_c = 1'b1;
					fin      = 1'b1;
				end
			end
		end
		if (!fin)
			inside_c = parity;
	end

	// Hold the result for its strobe cycle
	always_ff @(posedge clk) begin
		inside_q <= inside_c;
	end

	assign done       = done_q;
	assign inside_res = inside_q;

endmodule
